// ----- sv/stt_pkg.sv -----
// shared types, codes and constants for the segment table translate block
package stt_pkg;

    // default table depth and physical address width
    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int ADDR_BITS        = 32;

    // mask applied to a stored base address
    localparam logic [31:0] BASE_MASK =
        (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

    // request kinds
    localparam logic REQ_DEFINE    = 1'b0;
    localparam logic REQ_TRANSLATE = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MEM_FULL   = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_UNALLOC    = 3'd3;
    localparam logic [2:0] ST_RANGE      = 3'd4;

    // configuration register indexes
    localparam logic CFG_MEM_CAP   = 1'b0;
    localparam logic CFG_SEG_COUNT = 1'b1;

    // configuration reset values
    localparam logic [31:0] MEM_CAP_RST   = 32'd0;
    localparam logic [4:0]  SEG_COUNT_RST = 5'd16;

    // input request payload
    typedef struct packed {
        logic        req_type;
        logic [31:0] seg_length;
        logic [31:0] seg_base;
        logic [3:0]  seg_select;
        logic [31:0] seg_offset;
    } t_req;

    // result payload
    typedef struct packed {
        logic [2:0]  status;
        logic [32:0] phys_addr;
        logic [31:0] range_start;
        logic [32:0] range_end;
    } t_rsp;

    // controller commands to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

endpackage

// ----- sv/segment_table_translate_core.sv -----
// top level of the segment table translate block
//
// Requests enter on i_valid / o_stall and results leave on o_valid / i_stall;
// a request is taken at a clock edge with valid high and stall low.
// A define request fills the next table entry with a size and base, checked
// against the configured memory capacity and segment count. A translate
// request looks up a segment and returns base+offset and the segment range,
// or an unallocated / out-of-range status.
// The request edge moves the controller to S_EXEC, where the result register
// loads, and then to S_RESP, where o_valid is high until the result is taken.
// A new request is taken only after that, once the controller is back in
// S_IDLE, so the block does not overlap one request with the next.
// While the receiver stalls the result holds and no new request is taken.
// Reset (i_rst_n low, synchronous) empties the table through the fill count,
// clears the allocated total and restores capacity 0 and segment count 16;
// no clearing pass is needed. The user writes configuration through i_cfg_we,
// i_cfg_addr and i_cfg_wdata only while the block is idle; this is unchecked.
module segment_table_translate_core #(
    parameter int MAX_SEGMENTS = stt_pkg::MAX_SEGMENTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  stt_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output stt_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic          i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata
);

    stt_pkg::t_dp_cmd cmd;

    // controller
    stt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // datapath
    stt_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- sv/stt_ctrl.sv -----
// controller state machine: request accept, execute and result handoff
module stt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_stall,
    output logic             o_stall,
    output logic             o_valid,
    output stt_pkg::t_dp_cmd o_cmd
);

    stt_pkg::t_state r_state;
    stt_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            stt_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = stt_pkg::S_EXEC;
                end
            end
            stt_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = stt_pkg::S_RESP;
            end
            stt_pkg::S_RESP: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = stt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/stt_datapath.sv -----
// datapath: config registers, segment tables, allocation total and result register
module stt_datapath #(
    parameter int MAX_SEGMENTS = stt_pkg::MAX_SEGMENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stt_pkg::t_dp_cmd i_cmd,
    input  stt_pkg::t_req    i_req,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [31:0]      i_cfg_wdata,
    output stt_pkg::t_rsp    o_rsp
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int KW = (CW > 5) ? CW : 5;
    localparam int SW = (CW > 4) ? CW : 4;

    // segment tables
    logic [31:0] r_len_mem  [MAX_SEGMENTS];
    logic [31:0] r_base_mem [MAX_SEGMENTS];

    logic [31:0]   r_mem_cap;
    logic [4:0]    r_seg_count;
    logic [32:0]   r_total;
    logic [CW-1:0] r_count;
    stt_pkg::t_req r_req;
    logic          r_sel_ok;
    logic [31:0]   r_len_rd;
    logic [31:0]   r_base_rd;
    stt_pkg::t_rsp r_rsp;

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          table_full;
    logic [33:0]   sum;
    logic          mem_full;
    logic          len_we;
    logic          base_we;
    logic [31:0]   len_wdata;
    stt_pkg::t_rsp n_rsp;

    assign rd_addr = IW'(i_req.seg_select);
    assign wr_addr = IW'(r_count);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_cap   <= stt_pkg::MEM_CAP_RST;
            r_seg_count <= stt_pkg::SEG_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                stt_pkg::CFG_MEM_CAP:   r_mem_cap   <= i_cfg_wdata;
                stt_pkg::CFG_SEG_COUNT: r_seg_count <= i_cfg_wdata[4:0];
                default:                r_mem_cap   <= r_mem_cap;
            endcase
        end
    end

    // capture request, index check and table read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req;
            r_sel_ok  <= (SW'(i_req.seg_select) < SW'(r_count)) &&
                         (SW'(i_req.seg_select) < SW'(MAX_SEGMENTS));
            r_len_rd  <= r_len_mem[rd_addr];
            r_base_rd <= r_base_mem[rd_addr];
        end
    end

    // define decision
    always_comb begin
        table_full = (KW'(r_count) >= KW'(r_seg_count)) ||
                     (r_count >= CW'(MAX_SEGMENTS));
        sum        = {1'b0, r_total} + {2'b00, r_req.seg_length};
        mem_full   = sum > {2'b00, r_mem_cap};
        len_we     = i_cmd.exec && (r_req.req_type == stt_pkg::REQ_DEFINE) && !table_full;
        base_we    = len_we && !mem_full;
        len_wdata  = mem_full ? 32'd0 : r_req.seg_length;
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[wr_addr] <= len_wdata;
        end
        if (base_we) begin
            r_base_mem[wr_addr] <= r_req.seg_base & stt_pkg::BASE_MASK;
        end
    end

    // allocation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= 33'd0;
            r_count <= '0;
        end else begin
            if (len_we) begin
                r_count <= r_count + CW'(1);
            end
            if (base_we) begin
                r_total <= sum[32:0];
            end
        end
    end

    // result selection
    always_comb begin
        n_rsp = '0;
        if (r_req.req_type == stt_pkg::REQ_DEFINE) begin
            if (table_full) begin
                n_rsp.status = stt_pkg::ST_TABLE_FULL;
            end else if (mem_full) begin
                n_rsp.status = stt_pkg::ST_MEM_FULL;
            end else begin
                n_rsp.status = stt_pkg::ST_OK;
            end
        end else if (!r_sel_ok || (r_len_rd == 32'd0)) begin
            n_rsp.status = stt_pkg::ST_UNALLOC;
        end else if (r_req.seg_offset >= r_len_rd) begin
            n_rsp.status = stt_pkg::ST_RANGE;
        end else begin
            n_rsp.status      = stt_pkg::ST_OK;
            n_rsp.phys_addr   = {1'b0, r_base_rd} + {1'b0, r_req.seg_offset};
            n_rsp.range_start = r_base_rd;
            n_rsp.range_end   = {1'b0, r_base_rd} + {1'b0, r_len_rd};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ----- verif/tb_segment_table_translate_core.sv -----
// testbench for the segment table translate core: directed and random requests vs a predictor
`timescale 1ns / 100ps

module tb_segment_table_translate_core;

    localparam int TBL_DEPTH  = stt_pkg::MAX_SEGMENTS_DEF;
    localparam int CLK_HALF   = 6;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    stt_pkg::t_req i_req;
    logic          o_valid;
    logic          i_stall;
    stt_pkg::t_rsp o_rsp;
    logic          i_cfg_we;
    logic          i_cfg_addr;
    logic [31:0]   i_cfg_wdata;

    // predicted segment table and configuration
    logic [31:0] seg_len_tbl  [TBL_DEPTH];
    logic [31:0] seg_base_tbl [TBL_DEPTH];
    logic [32:0] alloc_total;
    logic [4:0]  n_defined;
    logic [31:0] mem_cap;
    logic [4:0]  seg_count_cfg;

    // results still owed by the block, oldest first
    stt_pkg::t_rsp pending_rsp_q [$];

    int mismatches   = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_req_cnt = 0;

    segment_table_translate_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // predictor: apply one request to the table copy, return the result it owes
    function automatic stt_pkg::t_rsp apply_request(input stt_pkg::t_req r);
        stt_pkg::t_rsp rsp;
        logic [4:0]    lim;
        logic [31:0]   len;
        logic [31:0]   base;
        rsp = '0;
        if (r.req_type == stt_pkg::REQ_DEFINE) begin
            lim = (seg_count_cfg < 5'(TBL_DEPTH)) ? seg_count_cfg : 5'(TBL_DEPTH);
            if (n_defined >= lim) begin
                rsp.status = stt_pkg::ST_TABLE_FULL;
            end else begin
                // 34-bit sum so the capacity check never wraps
                if ({1'b0, alloc_total} + 34'(r.seg_length) > 34'(mem_cap)) begin
                    seg_len_tbl[n_defined[3:0]] = '0;
                    rsp.status = stt_pkg::ST_MEM_FULL;
                end else begin
                    alloc_total = alloc_total + 33'(r.seg_length);
                    seg_len_tbl[n_defined[3:0]]  = r.seg_length;
                    seg_base_tbl[n_defined[3:0]] = r.seg_base & stt_pkg::BASE_MASK;
                    rsp.status = stt_pkg::ST_OK;
                end
                n_defined = n_defined + 5'd1;
            end
        end else begin
            len  = seg_len_tbl[r.seg_select];
            base = seg_base_tbl[r.seg_select];
            if (5'(r.seg_select) >= n_defined || len == '0) begin
                rsp.status = stt_pkg::ST_UNALLOC;
            end else if (r.seg_offset >= len) begin
                rsp.status = stt_pkg::ST_RANGE;
            end else begin
                rsp.status      = stt_pkg::ST_OK;
                rsp.phys_addr   = 33'(base) + 33'(r.seg_offset);
                rsp.range_start = base;
                rsp.range_end   = 33'(base) + 33'(len);
            end
        end
        return rsp;
    endfunction

    // request builders; fields the request kind ignores carry random bits
    function automatic stt_pkg::t_req define_req(input logic [31:0] len,
                                                 input logic [31:0] base);
        stt_pkg::t_req r;
        r.req_type   = stt_pkg::REQ_DEFINE;
        r.seg_length = len;
        r.seg_base   = base;
        r.seg_select = 4'($urandom);
        r.seg_offset = $urandom;
        return r;
    endfunction

    function automatic stt_pkg::t_req translate_req(input logic [3:0] sel,
                                                    input logic [31:0] off);
        stt_pkg::t_req r;
        r.req_type   = stt_pkg::REQ_TRANSLATE;
        r.seg_length = $urandom;
        r.seg_base   = $urandom;
        r.seg_select = sel;
        r.seg_offset = off;
        return r;
    endfunction

    // random request steered by the predicted table so translates hit the edges
    function automatic stt_pkg::t_req random_request();
        stt_pkg::t_req r;
        logic [32:0]   room;
        logic [31:0]   len;
        logic [3:0]    sel;
        int            pick;
        if ($urandom_range(0, 99) < 10) begin
            room = ({1'b0, mem_cap} > alloc_total) ? {1'b0, mem_cap} - alloc_total : '0;
            pick = $urandom_range(0, 19);
            if (pick < 2)
                len = '0;
            else if (pick == 2)
                len = room[31:0];
            else if (pick == 3)
                len = room[31:0] + 32'd1;
            else if (pick < 6)
                len = $urandom;
            else
                len = $urandom_range(1, 4096);
            r = define_req(len, $urandom);
        end else begin
            if (n_defined != '0 && $urandom_range(0, 99) < 85)
                sel = 4'($urandom_range(0, int'(n_defined) - 1));
            else
                sel = 4'($urandom_range(0, 15));
            len = seg_len_tbl[sel];
            r = translate_req(sel, $urandom);
            if (len != '0) begin
                case ($urandom_range(0, 7))
                    0: r.seg_offset = '0;
                    1: r.seg_offset = len - 32'd1;
                    2: r.seg_offset = len;
                    3: r.seg_offset = len + 32'($urandom_range(1, 16));
                    4: r.seg_offset = '1;
                    5: r.seg_offset = $urandom;
                    default: r.seg_offset = $urandom_range(0, len - 32'd1);
                endcase
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [32:0] want,
                                        input logic [32:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : rsp_check
        stt_pkg::t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rsp_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, expected nothing, got 0x%0h",
                         $time, o_rsp);
            end else begin
                want = pending_rsp_q.pop_front();
                check_field("status",      33'(want.status),      33'(o_rsp.status));
                check_field("phys_addr",   want.phys_addr,        o_rsp.phys_addr);
                check_field("range_start", 33'(want.range_start), 33'(o_rsp.range_start));
                check_field("range_end",   want.range_end,        o_rsp.range_end);
            end
        end
    end

    // result side stall, with a long hold-off on demand
    initial begin : rx_stall_gen
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req_cnt != hold_seen) begin
                hold_seen = hold_req_cnt;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // offer one request, wait for the handshake, record what it owes
    task automatic send_req(input stt_pkg::t_req r);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_rsp_q.push_back(apply_request(r));
    endtask

    // drop valid and wait until every result is back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        if (idx == stt_pkg::CFG_MEM_CAP)
            mem_cap = data;
        else
            seg_count_cfg = data[4:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // defaults after reset: capacity 0, zero-size and memory-full entries
    task automatic test_reset_defaults();
        send_req(translate_req(4'd0, 32'd0));
        send_req(define_req(32'd0, 32'hFFFF_FFFF));
        send_req(define_req(32'd1, 32'd0));
        send_req(translate_req(4'd0, 32'd0));
        send_req(translate_req(4'd1, 32'd0));
        send_req(translate_req(4'd15, 32'hFFFF_FFFF));
        drain();
    endtask

    // segment count limit, including zero; ends by writing a value past the table depth
    task automatic test_table_limit();
        cfg_write(stt_pkg::CFG_SEG_COUNT, 32'd0);
        send_req(define_req(32'd0, 32'd0));
        drain();
        cfg_write(stt_pkg::CFG_SEG_COUNT, 32'd2);
        send_req(define_req(32'd4, 32'd100));
        drain();
        cfg_write(stt_pkg::CFG_SEG_COUNT, 32'd1);
        send_req(define_req(32'd4, 32'd100));
        drain();
        cfg_write(stt_pkg::CFG_SEG_COUNT, 32'd31);
    endtask

    // full capacity, carry into bit 32, bound check at and past the size
    task automatic test_bounds();
        cfg_write(stt_pkg::CFG_MEM_CAP, 32'hFFFF_FFFF);
        send_req(define_req(32'h8000_0000, 32'hFFFF_FFFF));
        send_req(define_req(32'd3, 32'd0));
        send_req(define_req(32'hFFFF_FFFF, 32'h1234_5678));
        send_req(translate_req(4'd2, 32'd0));
        send_req(translate_req(4'd2, 32'h7FFF_FFFF));
        send_req(translate_req(4'd2, 32'h8000_0000));
        send_req(translate_req(4'd3, 32'd2));
        send_req(translate_req(4'd3, 32'd3));
        send_req(translate_req(4'd4, 32'd0));
        send_req(translate_req(4'd3, 32'hFFFF_FFFF));
        send_req(translate_req(4'd5, 32'd0));
        drain();
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct,
                                       input logic [31:0] cap, input logic [31:0] count);
        cfg_write(stt_pkg::CFG_MEM_CAP, cap);
        cfg_write(stt_pkg::CFG_SEG_COUNT, count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n_items) send_req(random_request());
        drain();
    endtask

    // long result stall while requests keep coming, so the input backs up
    task automatic test_input_backpressure(input int n_items);
        cfg_write(stt_pkg::CFG_SEG_COUNT, 32'd16);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req_cnt++;
        repeat (n_items) send_req(random_request());
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req         = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = stt_pkg::CFG_MEM_CAP;
        i_cfg_wdata   = '0;
        seg_len_tbl   = '{default: '0};
        seg_base_tbl  = '{default: '0};
        alloc_total   = '0;
        n_defined     = '0;
        mem_cap       = stt_pkg::MEM_CAP_RST;
        seg_count_cfg = stt_pkg::SEG_COUNT_RST;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_table_limit();
        test_bounds();
        // capacity below the running total: every define is refused
        test_random_traffic(700, 9, 88, 32'h0000_0100, 32'd7);
        test_random_traffic(700, 88, 9, 32'hFFFF_FFFF, 32'd12);
        test_input_backpressure(600);

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- segment_table_translate_core.f -----
sv/stt_pkg.sv
sv/stt_ctrl.sv
sv/stt_datapath.sv
sv/segment_table_translate_core.sv
verif/tb_segment_table_translate_core.sv
